// ===== design/rpg_pkg.sv =====
// ----------------------------------------------------------------------------
// rpg_pkg
// Shared widths, register indexes and controller states of the random
// permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpg_pkg;

  localparam int WORD_W        = 31;
  localparam int VALUE_W       = 32;
  localparam int ITEM_COUNT_W  = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int MAX_ITEMS_DEF = 1024;

  localparam logic [ITEM_COUNT_W-1:0] ITEM_COUNT_RST = 11'd1024;
  localparam logic [VALUE_W-1:0]      BASE_VALUE_RST = 32'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_VALUE = 2'd1;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIV,
    ST_GET_SLOT,
    ST_WR_SLOT,
    ST_WR_LAST
  } rpg_state_e;

endpackage

`default_nettype wire

// ===== design/random_permutation_generator.sv =====
// ----------------------------------------------------------------------------
// random_permutation_generator
// Fisher-Yates draw per input word: bit-serial remainder picks a slot, the
// table entry there plus base is emitted, and the last live entry is swapped
// in. Table entries carry a valid bit; a missing entry reads as its index.
// ----------------------------------------------------------------------------
// Per word: serial remainder (31 bits, one per cycle, then done), slot read,
//   two table writes on one RAM and a return to idle; no new word is taken
//   until the last table write is done, and a stalled output word holds it.
// Reset and every write to the item-count or base-value register start a
//   clearing pass over all MAX_ITEMS table entries; no input word is taken
//   until it ends.
`default_nettype none

module random_permutation_generator
  import rpg_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [WORD_W-1:0]       random_word_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [VALUE_W-1:0]      drawn_value_o,
  output logic                         pass_done_o
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W = (CNT_W > ITEM_COUNT_W) ? CNT_W : ITEM_COUNT_W;
  localparam int MEM_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] SWEEP_END = IDX_W'(MAX_ITEMS - 1);

  rpg_state_e state_q, state_d;

  logic [ITEM_COUNT_W-1:0] item_count_q, item_count_d;
  logic [VALUE_W-1:0]      base_value_q, base_value_d;
  logic [CNT_W-1:0]        remaining_q, remaining_d;
  logic [IDX_W-1:0]        sweep_q, sweep_d;
  logic                    out_valid_q, out_valid_d;
  logic [IDX_W-1:0]        last_q, last_d;
  logic [IDX_W-1:0]        slot_q, slot_d;
  logic [IDX_W-1:0]        moved_q, moved_d;
  logic [IDX_W-1:0]        chosen_q, chosen_d;
  logic [VALUE_W-1:0]      drawn_q, drawn_d;
  logic                    done_q, done_d;

  logic [CMP_W-1:0] cnt_ext, eff_ext;
  logic [CNT_W-1:0] eff_count;
  logic             cfg_hit;
  logic             in_accept;

  logic             div_done;
  logic [CNT_W-1:0] div_rem;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    cnt_ext = CMP_W'(item_count_q);
    if (cnt_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(MAX_ITEMS)) begin
      eff_ext = CMP_W'(MAX_ITEMS);
    end else begin
      eff_ext = cnt_ext;
    end
    eff_count = eff_ext[CNT_W-1:0];
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    cfg_hit      = 1'b0;
    item_count_d = item_count_q;
    base_value_d = base_value_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ITEM_COUNT: begin
          item_count_d = cfg_data_i[ITEM_COUNT_W-1:0];
          cfg_hit      = 1'b1;
        end
        CFG_BASE_VALUE: begin
          base_value_d = cfg_data_i[VALUE_W-1:0];
          cfg_hit      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    remaining_d = remaining_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    last_d      = last_q;
    slot_d      = slot_q;
    moved_d     = moved_q;
    chosen_d    = chosen_q;
    drawn_d     = drawn_q;
    done_d      = done_q;
    ram_we      = 1'b0;
    ram_waddr   = sweep_q;
    ram_wdata   = '0;
    ram_raddr   = last_q;

    case (state_q)
      ST_SWEEP: begin
        ram_we      = 1'b1;
        remaining_d = eff_count;
        sweep_d     = sweep_q + 1'b1;
        if (sweep_q == SWEEP_END) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        last_d    = IDX_W'(remaining_q - 1'b1);
        ram_raddr = last_d;
        if (in_accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slot_d    = div_rem[IDX_W-1:0];
          moved_d   = ram_rdata[IDX_W] ? ram_rdata[IDX_W-1:0] : last_q;
          ram_raddr = slot_d;
          state_d   = ST_GET_SLOT;
        end
      end
      ST_GET_SLOT: begin
        chosen_d = ram_rdata[IDX_W] ? ram_rdata[IDX_W-1:0] : slot_q;
        state_d  = ST_WR_SLOT;
      end
      ST_WR_SLOT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = {1'b1, moved_q};
        state_d   = ST_WR_LAST;
      end
      ST_WR_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = last_q;
        ram_wdata = {1'b1, chosen_q};
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          drawn_d     = base_value_q + VALUE_W'(chosen_q);
          done_d      = (last_q == '0);
          remaining_d = (last_q == '0) ? eff_count : CNT_W'(last_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
        sweep_d = '0;
      end
    endcase

    if (cfg_hit) begin
      state_d = ST_SWEEP;
      sweep_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_q      <= '0;
      out_valid_q  <= 1'b0;
      item_count_q <= ITEM_COUNT_RST;
      base_value_q <= BASE_VALUE_RST;
      remaining_q  <= '0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      out_valid_q  <= out_valid_d;
      item_count_q <= item_count_d;
      base_value_q <= base_value_d;
      remaining_q  <= remaining_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    slot_q   <= slot_d;
    moved_q  <= moved_d;
    chosen_q <= chosen_d;
    drawn_q  <= drawn_d;
    done_q   <= done_d;
  end

  rpg_rem_serial #(
    .CNT_W (CNT_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .dividend_i (random_word_i),
    .divisor_i  (remaining_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  rpg_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_ITEMS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign drawn_value_o = drawn_q;
  assign pass_done_o   = done_q;

endmodule

`default_nettype wire

// ===== design/rpg_ram.sv =====
// ----------------------------------------------------------------------------
// rpg_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/rpg_rem_serial.sv =====
// ----------------------------------------------------------------------------
// rpg_rem_serial
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module rpg_rem_serial
  import rpg_pkg::*;
#(
  parameter int CNT_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0]  divisor_i,
  output logic                   done_o,
  output logic      [CNT_W-1:0]  rem_o
);

  localparam int BIT_CNT_W = $clog2(WORD_W + 1);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_W);

  logic [WORD_W-1:0]    word_q, word_d;
  logic [CNT_W-1:0]     div_q, div_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;

  always_comb begin
    trial  = {rem_q, word_q[WORD_W-1]};
    diff   = trial - {1'b0, div_q};
    word_d = word_q;
    div_d  = div_q;
    rem_d  = rem_q;
    bit_d  = bit_q;
    if (start_i) begin
      word_d = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      bit_d  = '0;
    end else if (bit_q != LAST_BIT) begin
      word_d = {word_q[WORD_W-2:0], 1'b0};
      rem_d  = (trial >= {1'b0, div_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      bit_d  = bit_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= LAST_BIT;
    end else begin
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign done_o = (bit_q == LAST_BIT);
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: random_permutation_generator testbench
// Drives random words over a valid/ready channel and checks every drawn value
// and pass-done flag against a shuffle table kept alongside the block, across
// several count and base settings with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpg_pkg::*;

  localparam int TABLE_DEPTH   = MAX_ITEMS_DEF;
  localparam int STALL_MAX     = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 10000;
  localparam int SMALL_PHASES  = 12;
  localparam int FULL_ITEMS    = 1030;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [WORD_W-1:0]    WORD_ONES   = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] drawn_value;
    logic               pass_done;
  } draw_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic [WORD_W-1:0]       random_word_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [VALUE_W-1:0]      drawn_value_o;
  logic                    pass_done_o;

  logic [ITEM_COUNT_W-1:0] count_reg;
  logic [VALUE_W-1:0]      base_reg;
  int unsigned             left_count;
  int unsigned             slot_value [TABLE_DEPTH];
  bit                      slot_live  [TABLE_DEPTH];
  draw_t                   draw_q [$];
  int                      errors = 0;
  int                      quiet  = 0;
  bit                      calm   = 1'b0;

  random_permutation_generator dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned live_count();
    int unsigned c;
    c = count_reg;
    if (c == 0) c = 1;
    if (c > TABLE_DEPTH) c = TABLE_DEPTH;
    return c;
  endfunction

  function automatic void restart_pass();
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    left_count = live_count();
  endfunction

  function automatic draw_t predict_draw(logic [WORD_W-1:0] word);
    int unsigned count;
    int unsigned slot;
    int unsigned tail;
    int unsigned picked;
    int unsigned moved;
    draw_t d;
    count = live_count();
    if (left_count == 0 || left_count > count) left_count = count;
    slot   = int'(word) % left_count;
    tail   = left_count - 1;
    picked = slot_live[slot] ? slot_value[slot] : slot;
    moved  = slot_live[tail] ? slot_value[tail] : tail;
    slot_value[slot] = moved;
    slot_live[slot]  = 1'b1;
    slot_value[tail] = picked;
    slot_live[tail]  = 1'b1;
    left_count = tail;
    d.pass_done = (left_count == 0);
    if (d.pass_done) left_count = count;
    d.drawn_value = base_reg + VALUE_W'(picked);
    return d;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WORD_ONES;
      2: return WORD_W'($urandom_range(0, 2047));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ITEM_COUNT) begin
      count_reg = data[ITEM_COUNT_W-1:0];
      restart_pass();
    end else if (idx == CFG_BASE_VALUE) begin
      base_reg = data;
      restart_pass();
    end
  endtask

  task automatic send_word(logic [WORD_W-1:0] word);
    int gap;
    gap = calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_word_i <= word;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    draw_q.push_back(predict_draw(word));
  endtask

  // drop valid and wait for every outstanding draw
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (draw_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_table();
    send_word('0);
    send_word(WORD_ONES);
    send_word(31'h5555_5555);
    send_word(31'h2AAA_AAAA);
    send_word(31'd1023);
    send_word(31'd1024);
  endtask

  task automatic test_count_limits();
    drain();
    write_reg(CFG_ITEM_COUNT, '0);
    send_word(WORD_ONES);
    send_word(31'd7);
    drain();
    write_reg(CFG_ITEM_COUNT, 32'd2047);
    send_word(WORD_ONES);
    drain();
    write_reg(CFG_ITEM_COUNT, 32'd2);
    send_word(31'd1);
    send_word(31'd0);
    send_word(WORD_ONES);
  endtask

  task automatic test_base_wrap();
    drain();
    write_reg(CFG_BASE_VALUE, '1);
    write_reg(CFG_ITEM_COUNT, 32'd3);
    send_word(31'd2);
    drain();
    write_reg(CFG_SPARE_2, 32'd5);
    write_reg(CFG_SPARE_3, '1);
    send_word(WORD_ONES);
    send_word(31'd0);
    send_word(31'd4);
  endtask

  task automatic test_random_draws();
    int unsigned span;
    int unsigned n;
    for (int phase = 0; phase < SMALL_PHASES; phase++) begin
      drain();
      calm = (phase == 5);
      case (phase % 4)
        0: span = $urandom_range(2, 8);
        1: span = $urandom_range(9, 48);
        2: span = $urandom_range(0, 1);
        default: span = $urandom_range(TABLE_DEPTH + 1, 2047);
      endcase
      if (phase % 2 == 0) write_reg(CFG_ITEM_COUNT, span);
      case (phase % 6)
        1: write_reg(CFG_BASE_VALUE, '1);
        3: write_reg(CFG_BASE_VALUE, '0);
        default: write_reg(CFG_BASE_VALUE, $urandom);
      endcase
      if (phase % 2 != 0) write_reg(CFG_ITEM_COUNT, span);
      n = (live_count() > 64) ? $urandom_range(8, 24)
                              : 2 * live_count() + $urandom_range(0, 3);
      repeat (n) send_word(pick_word());
    end
    drain();
    calm = 1'b0;
    write_reg(CFG_BASE_VALUE, $urandom);
    write_reg(CFG_ITEM_COUNT, TABLE_DEPTH);
    for (int k = 0; k < FULL_ITEMS; k++) begin
      if (k == 512) drain();
      calm = (k >= 700 && k < 800);
      send_word(pick_word());
    end
    calm = 1'b0;
  endtask

  initial begin : draw_check
    int    stall;
    draw_t want;
    forever begin
      stall = calm ? 0 : $urandom_range(0, STALL_MAX);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      if (draw_q.size() == 0) begin
        $error("drawn_value: expected none, got %h", drawn_value_o);
        errors++;
      end else begin
        want = draw_q.pop_front();
        if (drawn_value_o !== want.drawn_value) begin
          $error("drawn_value: expected %h, got %h", want.drawn_value, drawn_value_o);
          errors++;
        end
        if (pass_done_o !== want.pass_done) begin
          $error("pass_done: expected %b, got %b", want.pass_done, pass_done_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("random_permutation_generator regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    count_reg = ITEM_COUNT_RST;
    base_reg  = BASE_VALUE_RST;
    restart_pass();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_table();
    test_count_limits();
    test_base_wrap();
    test_random_draws();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && draw_q.size() == 0) begin
      $display("random_permutation_generator regression: pass");
    end else begin
      $display("random_permutation_generator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
